[rtl/viewbox_fit_transform_assert.svh]
// Assertion macros for the view box fit transform.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef VIEWBOX_FIT_TRANSFORM_ASSERT_SVH
`define VIEWBOX_FIT_TRANSFORM_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VFT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vft_pkg.sv]
// Package for the view box fit transform: register indexes, mode codes,
// divider request and sideband types, and the alignment decode. No dependencies.
`default_nettype none

package vft_pkg;

	localparam int DIV_STEPS = 32;
	localparam int LANES     = 4;
	localparam int CFG_W     = 4;
	localparam int IDX_W     = 2;

	localparam int LANE_SX = 0;
	localparam int LANE_SY = 1;
	localparam int LANE_OX = 2;
	localparam int LANE_OY = 3;

	localparam logic [IDX_W-1:0] REG_ALIGN = 2'd0;
	localparam logic [IDX_W-1:0] REG_FIT   = 2'd1;

	localparam logic [3:0] ALIGN_UNKNOWN   = 4'd0;
	localparam logic [3:0] ALIGN_NONE      = 4'd1;
	localparam logic [3:0] ALIGN_XMIN_YMIN = 4'd2;
	localparam logic [3:0] ALIGN_XMID_YMIN = 4'd3;
	localparam logic [3:0] ALIGN_XMAX_YMIN = 4'd4;
	localparam logic [3:0] ALIGN_XMIN_YMID = 4'd5;
	localparam logic [3:0] ALIGN_XMID_YMID = 4'd6;
	localparam logic [3:0] ALIGN_XMAX_YMID = 4'd7;
	localparam logic [3:0] ALIGN_XMIN_YMAX = 4'd8;
	localparam logic [3:0] ALIGN_XMID_YMAX = 4'd9;
	localparam logic [3:0] ALIGN_XMAX_YMAX = 4'd10;

	localparam logic [1:0] FIT_UNKNOWN = 2'd0;
	localparam logic [1:0] FIT_MEET    = 2'd1;
	localparam logic [1:0] FIT_SLICE   = 2'd2;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] low;
		logic [32:0] den;
	} vft_div_req_t;

	typedef struct packed {
		logic             ident;
		logic             err;
		logic             uniform;
		logic             neg_x;
		logic             neg_y;
		logic [LANES-1:0] ovf;
	} vft_ctrl_t;

	// Returns {kx, ky}: 0 for min, 1 for mid, 2 for max.
	function automatic logic [3:0] align_k(input logic [3:0] code);
		logic [3:0] k;
		case (code)
			ALIGN_XMIN_YMIN: k = {2'd0, 2'd0};
			ALIGN_XMID_YMIN: k = {2'd1, 2'd0};
			ALIGN_XMAX_YMIN: k = {2'd2, 2'd0};
			ALIGN_XMIN_YMID: k = {2'd0, 2'd1};
			ALIGN_XMID_YMID: k = {2'd1, 2'd1};
			ALIGN_XMAX_YMID: k = {2'd2, 2'd1};
			ALIGN_XMIN_YMAX: k = {2'd0, 2'd2};
			ALIGN_XMID_YMAX: k = {2'd1, 2'd2};
			ALIGN_XMAX_YMAX: k = {2'd2, 2'd2};
			default:         k = 4'd0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[rtl/vft_front.sv]
// Six-stage setup pipeline: cross products, branch selection, offset products,
// signed sums and divider set-up for the four quotient lanes. Uses vft_pkg.
`default_nettype none

module vft_front import vft_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic signed [31:0]        view_x,
	input  wire logic signed [31:0]        view_y,
	input  wire logic [30:0]               view_width,
	input  wire logic [30:0]               view_height,
	input  wire logic [30:0]               port_width,
	input  wire logic [30:0]               port_height,
	input  wire logic [3:0]                align_mode,
	input  wire logic [1:0]                fit_mode,
	output logic                           valid_s6,
	output vft_ctrl_t                      ctrl_s6,
	output vft_div_req_t [LANES-1:0]       req_s6
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	logic [31:0] vx_s1, vy_s1;
	logic [30:0] vw_s1, vh_s1, pw_s1, ph_s1;
	logic [61:0] p_s1, q_s1;
	logic [3:0]  k_s1;
	logic [1:0]  fit_s1;
	logic        ident_s1, err_s1, none_s1;

	logic [31:0] absx_s2, absy_s2;
	logic [30:0] mulx_s2, muly_s2, denx_s2, deny_s2;
	logic [1:0]  kx_s2, ky_s2;
	logic [61:0] dmag_s2;
	logic        n1x_s2, n1y_s2, n2x_s2, n2y_s2;
	logic        ident_s2, err_s2, uniform_s2;

	logic [63:0] m1x_s3, m1y_s3;
	logic [62:0] m2x_s3, m2y_s3;
	logic [30:0] mulx_s3, muly_s3, denx_s3, deny_s3;
	logic        n1x_s3, n1y_s3, n2x_s3, n2y_s3;
	logic        ident_s3, err_s3, uniform_s3;

	logic [65:0] valx_s4, valy_s4;
	logic [63:0] numx_s4, numy_s4;
	logic [30:0] denx_s4, deny_s4;
	logic        ident_s4, err_s4, uniform_s4;

	logic [63:0] magx_s5, magy_s5, numx_s5, numy_s5;
	logic [30:0] denx_s5, deny_s5;
	logic        negx_s5, negy_s5;
	logic        ident_s5, err_s5, uniform_s5;

	logic known, zero;
	logic p_less, use_h, hx, hy;
	logic [61:0] dmag;
	logic [62:0] prodx, prody;
	logic [65:0] t1x, t1y, t2x, t2y;
	logic [32:0] dsx, dsy, dox, doy;

	always_comb begin
		known = (align_mode >= ALIGN_NONE) && (align_mode <= ALIGN_XMAX_YMAX);
		zero  = (view_width == 31'd0) || (view_height == 31'd0) ||
			(port_width == 31'd0) || (port_height == 31'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1    <= view_x;
			vy_s1    <= view_y;
			vw_s1    <= view_width;
			vh_s1    <= view_height;
			pw_s1    <= port_width;
			ph_s1    <= port_height;
			p_s1     <= {31'd0, port_height} * {31'd0, view_width};
			q_s1     <= {31'd0, port_width} * {31'd0, view_height};
			k_s1     <= align_k(align_mode);
			fit_s1   <= fit_mode;
			ident_s1 <= !known || zero;
			err_s1   <= known && zero;
			none_s1  <= (align_mode == ALIGN_NONE);
		end
	end

	always_comb begin
		p_less = p_s1 < q_s1;
		dmag   = p_less ? (q_s1 - p_s1) : (p_s1 - q_s1);
		use_h  = ((fit_s1 == FIT_MEET) && p_less) || ((fit_s1 == FIT_SLICE) && !p_less);
		hx     = !none_s1 && use_h;
		hy     = none_s1 || use_h;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			absx_s2    <= vx_s1[31] ? (32'd0 - vx_s1) : vx_s1;
			absy_s2    <= vy_s1[31] ? (32'd0 - vy_s1) : vy_s1;
			mulx_s2    <= hx ? ph_s1 : pw_s1;
			denx_s2    <= hx ? vh_s1 : vw_s1;
			muly_s2    <= hy ? ph_s1 : pw_s1;
			deny_s2    <= hy ? vh_s1 : vw_s1;
			kx_s2      <= hx ? k_s1[3:2] : 2'd0;
			ky_s2      <= (!none_s1 && !use_h) ? k_s1[1:0] : 2'd0;
			dmag_s2    <= dmag;
			n1x_s2     <= !vx_s1[31] && (vx_s1 != 32'd0);
			n1y_s2     <= !vy_s1[31] && (vy_s1 != 32'd0);
			n2x_s2     <= !p_less;
			n2y_s2     <= p_less;
			ident_s2   <= ident_s1;
			err_s2     <= err_s1;
			uniform_s2 <= !none_s1;
		end
	end

	always_comb begin
		prodx = {31'd0, absx_s2} * {32'd0, mulx_s2};
		prody = {31'd0, absy_s2} * {32'd0, muly_s2};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1x_s3     <= {prodx, 1'b0};
			m1y_s3     <= {prody, 1'b0};
			m2x_s3     <= (kx_s2 == 2'd2) ? {dmag_s2, 1'b0} :
				(kx_s2 == 2'd1) ? {1'b0, dmag_s2} : 63'd0;
			m2y_s3     <= (ky_s2 == 2'd2) ? {dmag_s2, 1'b0} :
				(ky_s2 == 2'd1) ? {1'b0, dmag_s2} : 63'd0;
			mulx_s3    <= mulx_s2;
			muly_s3    <= muly_s2;
			denx_s3    <= denx_s2;
			deny_s3    <= deny_s2;
			n1x_s3     <= n1x_s2;
			n1y_s3     <= n1y_s2;
			n2x_s3     <= n2x_s2;
			n2y_s3     <= n2y_s2;
			ident_s3   <= ident_s2;
			err_s3     <= err_s2;
			uniform_s3 <= uniform_s2;
		end
	end

	always_comb begin
		t1x = n1x_s3 ? (66'd0 - {2'd0, m1x_s3}) : {2'd0, m1x_s3};
		t1y = n1y_s3 ? (66'd0 - {2'd0, m1y_s3}) : {2'd0, m1y_s3};
		t2x = n2x_s3 ? (66'd0 - {3'd0, m2x_s3}) : {3'd0, m2x_s3};
		t2y = n2y_s3 ? (66'd0 - {3'd0, m2y_s3}) : {3'd0, m2y_s3};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			valx_s4    <= t1x + t2x;
			valy_s4    <= t1y + t2y;
			numx_s4    <= ({33'd0, mulx_s3} << FRAC_BITS) + {34'd0, denx_s3[30:1]};
			numy_s4    <= ({33'd0, muly_s3} << FRAC_BITS) + {34'd0, deny_s3[30:1]};
			denx_s4    <= denx_s3;
			deny_s4    <= deny_s3;
			ident_s4   <= ident_s3;
			err_s4     <= err_s3;
			uniform_s4 <= uniform_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			magx_s5    <= valx_s4[65] ? 64'(66'd0 - valx_s4) : valx_s4[63:0];
			magy_s5    <= valy_s4[65] ? 64'(66'd0 - valy_s4) : valy_s4[63:0];
			negx_s5    <= valx_s4[65];
			negy_s5    <= valy_s4[65];
			numx_s5    <= numx_s4;
			numy_s5    <= numy_s4;
			denx_s5    <= denx_s4;
			deny_s5    <= deny_s4;
			ident_s5   <= ident_s4;
			err_s5     <= err_s4;
			uniform_s5 <= uniform_s4;
		end
	end

	always_comb begin
		dsx = {2'd0, denx_s5};
		dsy = {2'd0, deny_s5};
		dox = {1'b0, denx_s5, 1'b0};
		doy = {1'b0, deny_s5, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s6[LANE_SX] <= '{rem: {1'b0, numx_s5[63:32]}, low: numx_s5[31:0], den: dsx};
			req_s6[LANE_SY] <= '{rem: {1'b0, numy_s5[63:32]}, low: numy_s5[31:0], den: dsy};
			req_s6[LANE_OX] <= '{rem: {1'b0, magx_s5[63:32]}, low: magx_s5[31:0], den: dox};
			req_s6[LANE_OY] <= '{rem: {1'b0, magy_s5[63:32]}, low: magy_s5[31:0], den: doy};
			ctrl_s6.ident   <= ident_s5;
			ctrl_s6.err     <= err_s5;
			ctrl_s6.uniform <= uniform_s5;
			ctrl_s6.neg_x   <= negx_s5;
			ctrl_s6.neg_y   <= negy_s5;
			ctrl_s6.ovf[LANE_SX] <= {1'b0, numx_s5[63:32]} >= dsx;
			ctrl_s6.ovf[LANE_SY] <= {1'b0, numy_s5[63:32]} >= dsy;
			ctrl_s6.ovf[LANE_OX] <= {1'b0, magx_s5[63:32]} >= dox;
			ctrl_s6.ovf[LANE_OY] <= {1'b0, magy_s5[63:32]} >= doy;
		end
	end

endmodule

`default_nettype wire

[rtl/vft_div_lane.sv]
// Pipelined restoring divider lane: one quotient bit per stage, 32 stages.
// Uses the request type from vft_pkg.
`default_nettype none

module vft_div_lane import vft_pkg::*; (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire vft_div_req_t req,
	output logic [31:0]       quo,
	output logic [32:0]       rem,
	output logic [32:0]       den
);

	logic [32:0] rem_s [DIV_STEPS];
	logic [31:0] low_s [DIV_STEPS];
	logic [31:0] quo_s [DIV_STEPS];
	logic [32:0] den_s [DIV_STEPS];

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [32:0] rem_in, den_in;
		logic [31:0] low_in, quo_in;
		logic [33:0] trial;
		logic        fits;

		if (i == 0) begin : g_first
			assign rem_in = req.rem;
			assign low_in = req.low;
			assign den_in = req.den;
			assign quo_in = 32'd0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign low_in = low_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign trial = {rem_in, low_in[31]};
		assign fits  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? 33'(trial - {1'b0, den_in}) : trial[32:0];
				low_s[i] <= {low_in[30:0], 1'b0};
				quo_s[i] <= {quo_in[30:0], fits};
				den_s[i] <= den_in;
			end
		end
	end

	assign quo = quo_s[DIV_STEPS-1];
	assign rem = rem_s[DIV_STEPS-1];
	assign den = den_s[DIV_STEPS-1];

endmodule

`default_nettype wire

[rtl/viewbox_fit_transform.sv]
// Channel | handshake          | payload
// input   | in_valid/in_ready  | view_x, view_y, view_width, view_height, port_width, port_height
// output  | out_valid/out_ready| scale_x, scale_y, offset_x, offset_y, size_error
// config  | cfg_we             | cfg_index, cfg_data
//
// One request enters per cycle while in_ready is high; each result passes through six
// set-up stages, 32 divider stages at one quotient bit each and one output register.
// Reset clears the valid bits and sets align_mode to xMidYMid and fit_mode to meet.
// A stall at the output freezes the whole pipeline; in_ready stays high while
// the output register is empty or being taken.
//
// Top level of the view box fit transform; uses vft_pkg, vft_front and vft_div_lane.
`default_nettype none
`include "viewbox_fit_transform_assert.svh"

module viewbox_fit_transform import vft_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] view_x,
	input  wire logic signed [31:0] view_y,
	input  wire logic [30:0]        view_width,
	input  wire logic [30:0]        view_height,
	input  wire logic [30:0]        port_width,
	input  wire logic [30:0]        port_height,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [30:0]             scale_x,
	output logic [30:0]             scale_y,
	output logic signed [31:0]      offset_x,
	output logic signed [31:0]      offset_y,
	output logic                    size_error
);

	localparam logic [30:0] IDENT = 31'(64'd1 << FRAC_BITS);

	logic [3:0] align_q;
	logic [1:0] fit_q;
	logic       en;
	logic       uniform_q;

	logic                     valid_s6;
	vft_ctrl_t                ctrl_s6;
	vft_div_req_t [LANES-1:0] req_s6;

	logic [31:0] quo [LANES];
	logic [32:0] rem [LANES];
	logic [32:0] den [LANES];

	vft_ctrl_t              ctrl_s [DIV_STEPS];
	logic [DIV_STEPS-1:0]   v_s;

	vft_ctrl_t   ctl;
	logic [30:0] sx_n, sy_n;
	logic [31:0] ox_n, oy_n;
	logic        rnd_x, rnd_y;
	logic [32:0] qx, qy;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= ALIGN_XMID_YMID;
			fit_q   <= FIT_MEET;
		end else if (cfg_we) begin
			if (cfg_index == REG_ALIGN) begin
				align_q <= cfg_data[3:0];
			end
			if (cfg_index == REG_FIT) begin
				fit_q <= cfg_data[1:0];
			end
		end
	end

	vft_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.view_x      (view_x),
		.view_y      (view_y),
		.view_width  (view_width),
		.view_height (view_height),
		.port_width  (port_width),
		.port_height (port_height),
		.align_mode  (align_q),
		.fit_mode    (fit_q),
		.valid_s6    (valid_s6),
		.ctrl_s6     (ctrl_s6),
		.req_s6      (req_s6)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		vft_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.req (req_s6[l]),
			.quo (quo[l]),
			.rem (rem[l]),
			.den (den[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STEPS-2:0], valid_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctrl_s[0] <= ctrl_s6;
			for (int i = 1; i < DIV_STEPS; i++) begin
				ctrl_s[i] <= ctrl_s[i-1];
			end
		end
	end

	always_comb begin
		ctl   = ctrl_s[DIV_STEPS-1];
		rnd_x = {rem[LANE_OX], 1'b0} >= {1'b0, den[LANE_OX]};
		rnd_y = {rem[LANE_OY], 1'b0} >= {1'b0, den[LANE_OY]};
		qx    = {1'b0, quo[LANE_OX]} + {32'd0, rnd_x};
		qy    = {1'b0, quo[LANE_OY]} + {32'd0, rnd_y};

		sx_n = (ctl.ovf[LANE_SX] || quo[LANE_SX][31]) ? 31'h7FFF_FFFF : quo[LANE_SX][30:0];
		sy_n = (ctl.ovf[LANE_SY] || quo[LANE_SY][31]) ? 31'h7FFF_FFFF : quo[LANE_SY][30:0];

		if (ctl.neg_x) begin
			ox_n = (ctl.ovf[LANE_OX] || qx > 33'h0_8000_0000) ? 32'h8000_0000 :
				32'd0 - qx[31:0];
		end else begin
			ox_n = (ctl.ovf[LANE_OX] || qx > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qx[31:0];
		end
		if (ctl.neg_y) begin
			oy_n = (ctl.ovf[LANE_OY] || qy > 33'h0_8000_0000) ? 32'h8000_0000 :
				32'd0 - qy[31:0];
		end else begin
			oy_n = (ctl.ovf[LANE_OY] || qy > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qy[31:0];
		end

		if (ctl.ident) begin
			sx_n = IDENT;
			sy_n = IDENT;
			ox_n = 32'd0;
			oy_n = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_x    <= sx_n;
			scale_y    <= sy_n;
			offset_x   <= ox_n;
			offset_y   <= oy_n;
			size_error <= ctl.err;
			uniform_q  <= ctl.uniform;
		end
	end

	`VFT_ASSERT_IMP(a_err_identity, out_valid && size_error,
		scale_x == IDENT && scale_y == IDENT && offset_x == 32'd0 && offset_y == 32'd0,
		"size error result is not the identity")
	`VFT_ASSERT_IMP(a_uniform_scale, out_valid && uniform_q, scale_x == scale_y,
		"uniform fit produced unequal scales")
	`VFT_ASSERT_NXT(a_stall_holds, !en, $stable(v_s),
		"divider pipeline moved during a stall")

endmodule

`default_nettype wire

[verif/viewbox_fit_transform_tb.sv]
// Self-checking testbench for viewbox_fit_transform: directed table, then random view boxes
// under several register settings and handshake idling patterns, against a local predictor.
// Depends on vft_pkg and the viewbox_fit_transform RTL.
`default_nettype none

module viewbox_fit_transform_tb;
	import vft_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam logic [3:0]       ALIGN_BAD    = 4'd15;
	localparam logic [1:0]       FIT_BAD      = 2'd3;
	localparam logic [30:0]      ONE          = 31'h10000;
	localparam logic [30:0]      MAX31        = 31'h7fffffff;
	localparam int               HOLD_CYCLES  = 300;
	localparam int               STALL_LIMIT  = 4000;

	typedef struct {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [30:0]        vw;
		logic [30:0]        vh;
		logic [30:0]        pw;
		logic [30:0]        ph;
	} box_req_t;

	typedef struct packed {
		logic [30:0] sx;
		logic [30:0] sy;
		logic [31:0] ox;
		logic [31:0] oy;
		logic        err;
	} fit_res_t;

	typedef struct {
		logic [3:0] align;
		logic [1:0] fit;
		box_req_t   req;
		bit         typed;
		fit_res_t   res;
	} table_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] view_x = '0;
	logic signed [31:0] view_y = '0;
	logic [30:0]        view_width = '0;
	logic [30:0]        view_height = '0;
	logic [30:0]        port_width = '0;
	logic [30:0]        port_height = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [30:0]        scale_x;
	logic [30:0]        scale_y;
	logic signed [31:0] offset_x;
	logic signed [31:0] offset_y;
	logic               size_error;

	logic [3:0] cur_align = ALIGN_XMID_YMID;
	logic [1:0] cur_fit   = FIT_MEET;
	fit_res_t   pending_fits[$];
	int         errors = 0;
	int         send_idle = 0;
	int         recv_stall = 0;
	bit         hold_req = 1'b0;
	int         quiet_cycles = 0;

	viewbox_fit_transform u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.view_x(view_x), .view_y(view_y), .view_width(view_width),
		.view_height(view_height), .port_width(port_width), .port_height(port_height),
		.out_valid(out_valid), .out_ready(out_ready),
		.scale_x(scale_x), .scale_y(scale_y), .offset_x(offset_x),
		.offset_y(offset_y), .size_error(size_error)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	function automatic logic [30:0] scale_calc(input bit [63:0] num, input bit [63:0] den);
		bit [63:0] q;
		q = ((num << 16) + (den >> 1)) / den;
		return (q > 64'h7fffffff) ? MAX31 : q[30:0];
	endfunction

	// (-2*pos*mul - k*diff) / (2*den), nearest with ties away from zero, saturated.
	function automatic logic [31:0] offset_calc(input longint pos, input bit [63:0] mul,
			input bit [63:0] k, input bit diff_neg, input bit [63:0] diff_mag,
			input bit [63:0] den);
		bit [63:0] apos, m1, m2, mag, d, q, r;
		bit        n1, n2, neg;
		apos = (pos < 0) ? -pos : pos;
		m1 = 2 * apos * mul;
		n1 = (pos > 0) && (m1 != 0);
		m2 = k * diff_mag;
		n2 = !diff_neg && (m2 != 0);
		if (n1 == n2) begin
			mag = m1 + m2;
			neg = n1;
		end else if (m1 >= m2) begin
			mag = m1 - m2;
			neg = n1;
		end else begin
			mag = m2 - m1;
			neg = n2;
		end
		d = 2 * den;
		q = mag / d;
		r = mag % d;
		if (2 * r >= d) q++;
		if (neg) begin
			if (q > 64'h80000000) q = 64'h80000000;
			return -q[31:0];
		end
		return (q > 64'h7fffffff) ? 32'h7fffffff : q[31:0];
	endfunction

	function automatic fit_res_t fit_predict(input box_req_t r);
		fit_res_t  f;
		bit [63:0] vw, vh, pw, ph, p, q, dmag, kx, ky;
		bit        p_less, use_h;
		vw = {33'd0, r.vw}; vh = {33'd0, r.vh}; pw = {33'd0, r.pw}; ph = {33'd0, r.ph};
		f = '{sx: ONE, sy: ONE, ox: '0, oy: '0, err: 1'b0};
		if (cur_align >= ALIGN_NONE && cur_align <= ALIGN_XMAX_YMAX) begin
			if (vw == 0 || vh == 0 || pw == 0 || ph == 0) begin
				f.err = 1'b1;
			end else if (cur_align == ALIGN_NONE) begin
				f.sx = scale_calc(pw, vw);
				f.sy = scale_calc(ph, vh);
				f.ox = offset_calc(longint'(r.vx), pw, 64'd0, 1'b0, 64'd0, vw);
				f.oy = offset_calc(longint'(r.vy), ph, 64'd0, 1'b0, 64'd0, vh);
			end else begin
				kx = (cur_align - ALIGN_XMIN_YMIN) % 3;
				ky = (cur_align - ALIGN_XMIN_YMIN) / 3;
				p = ph * vw;
				q = pw * vh;
				p_less = p < q;
				dmag = p_less ? q - p : p - q;
				use_h = (cur_fit == FIT_MEET && p_less) || (cur_fit == FIT_SLICE && !p_less);
				if (use_h) begin
					f.sx = scale_calc(ph, vh);
					f.ox = offset_calc(longint'(r.vx), ph, kx, p_less, dmag, vh);
					f.oy = offset_calc(longint'(r.vy), ph, 64'd0, 1'b0, 64'd0, vh);
				end else begin
					f.sx = scale_calc(pw, vw);
					f.ox = offset_calc(longint'(r.vx), pw, 64'd0, 1'b0, 64'd0, vw);
					f.oy = offset_calc(longint'(r.vy), pw, ky, !p_less, dmag, vw);
				end
				f.sy = f.sx;
			end
		end
		return f;
	endfunction

	function automatic logic [30:0] rand_size();
		int unsigned sel;
		logic [30:0] v;
		sel = $urandom_range(99);
		if (sel < 3) return '0;
		if (sel < 6) return MAX31;
		v = 31'($urandom >> $urandom_range(1, 31));
		return (v == 31'd0) ? 31'd1 : v;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_ALIGN) cur_align = val;
		else if (idx == REG_FIT) cur_fit = val[1:0];
	endtask

	// Registers change only with the pipeline drained.
	task automatic set_modes(input logic [3:0] align, input logic [1:0] fit);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_fits.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
		write_reg(REG_ALIGN, align);
		write_reg(REG_FIT, {2'b00, fit});
		write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic send_req(input box_req_t r, input bit typed, input fit_res_t want);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		view_x <= r.vx;
		view_y <= r.vy;
		view_width <= r.vw;
		view_height <= r.vh;
		port_width <= r.pw;
		port_height <= r.ph;
		do @(posedge clk); while (!in_ready);
		pending_fits.push_back(typed ? want : fit_predict(r));
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		fit_res_t want;
		if (out_valid && out_ready) begin
			if (pending_fits.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
			end else begin
				want = pending_fits.pop_front();
				if (scale_x !== want.sx) begin
					$display("%0t: scale_x exp %h got %h", $time, want.sx, scale_x);
					errors++;
				end
				if (scale_y !== want.sy) begin
					$display("%0t: scale_y exp %h got %h", $time, want.sy, scale_y);
					errors++;
				end
				if (offset_x !== want.ox) begin
					$display("%0t: offset_x exp %h got %h", $time, want.ox, offset_x);
					errors++;
				end
				if (offset_y !== want.oy) begin
					$display("%0t: offset_y exp %h got %h", $time, want.oy, offset_y);
					errors++;
				end
				if (size_error !== want.err) begin
					$display("%0t: size_error exp %b got %b", $time, want.err, size_error);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		table_row_t rows[$];
		fit_res_t   ident, bad;
		box_req_t   r, unit;
		logic [3:0] a;
		logic [1:0] f;
		ident = '{sx: ONE, sy: ONE, ox: '0, oy: '0, err: 1'b0};
		bad = ident;
		bad.err = 1'b1;
		unit = '{vx: 32'sd0, vy: 32'sd0, vw: ONE, vh: ONE, pw: ONE, ph: ONE};
		r = '{vx: 32'h80000000, vy: 32'h7fffffff, vw: MAX31, vh: 31'd1, pw: 31'd1,
			ph: MAX31};
		rows.push_back('{ALIGN_XMID_YMID, FIT_MEET, unit, 1'b1, ident});
		rows.push_back('{ALIGN_UNKNOWN, FIT_MEET, r, 1'b1, ident});
		rows.push_back('{ALIGN_BAD, FIT_BAD, r, 1'b1, ident});
		rows.push_back('{ALIGN_NONE, FIT_MEET, '{32'sd5, -32'sd5, 31'd0, ONE, ONE, ONE},
			1'b1, bad});
		rows.push_back('{ALIGN_XMID_YMID, FIT_SLICE, '{32'sd5, 32'sd5, ONE, 31'd0, ONE, ONE},
			1'b1, bad});
		rows.push_back('{ALIGN_XMAX_YMAX, FIT_MEET, '{32'sd5, 32'sd5, ONE, ONE, 31'd0, ONE},
			1'b1, bad});
		rows.push_back('{ALIGN_XMIN_YMIN, FIT_UNKNOWN, '{32'sd5, 32'sd5, ONE, ONE, ONE,
			31'd0}, 1'b1, bad});
		rows.push_back('{ALIGN_NONE, FIT_MEET, r, 1'b0, ident});
		rows.push_back('{ALIGN_NONE, FIT_SLICE, '{32'h7fffffff, 32'h80000000, 31'd1, 31'd1,
			MAX31, MAX31}, 1'b0, ident});
		for (int i = ALIGN_XMIN_YMIN; i <= ALIGN_XMAX_YMAX; i++) begin
			rows.push_back('{4'(i), FIT_MEET, '{-32'sd70000, 32'sd90000, 31'h30000,
				31'h10000, 31'h20000, 31'h40000}, 1'b0, ident});
			rows.push_back('{4'(i), (i % 2) ? FIT_SLICE : FIT_BAD, '{32'sd12345, -32'sd999,
				31'h10000, 31'h50000, 31'h70000, 31'h20000}, 1'b0, ident});
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].align != cur_align || rows[i].fit != cur_fit)
				set_modes(rows[i].align, rows[i].fit);
			send_req(rows[i].req, rows[i].typed, rows[i].res);
		end
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin a = ALIGN_XMID_YMID; f = FIT_MEET; end
				1: begin a = ALIGN_NONE; f = FIT_SLICE; end
				2: begin a = ALIGN_XMAX_YMAX; f = FIT_UNKNOWN; end
				3: begin a = ALIGN_XMIN_YMIN; f = FIT_BAD; end
				4: begin a = ALIGN_UNKNOWN; f = FIT_SLICE; end
				5: begin a = ALIGN_BAD; f = FIT_MEET; end
				default: begin
					a = 4'($urandom_range(ALIGN_NONE, ALIGN_XMAX_YMAX));
					f = 2'($urandom_range(0, 3));
				end
			endcase
			set_modes(a, f);
			send_idle = (ph % 4 == 1) ? 86 : (ph % 4 == 3) ? 30 : 0;
			recv_stall = (ph % 4 == 2) ? 86 : (ph % 4 == 3) ? 30 : 0;
			for (int n = 0; n < 120; n++) begin
				if (ph == 0 && n == 20) hold_req = 1'b1;
				if (ph == 0 && n == 80) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_fits.size() != 0) @(posedge clk);
				end
				r.vx = $urandom;
				r.vy = $urandom;
				r.vw = rand_size();
				r.vh = rand_size();
				r.pw = rand_size();
				r.ph = rand_size();
				send_req(r, 1'b0, ident);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_fits.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
